@@ rtl/bpt_pkg.sv @@
package bpt_pkg;

  // Field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned MODE_W  = 2;

  // Defaults for the top level
  localparam int unsigned DEFAULT_TIME_BITS = 16;
  localparam logic [LEN_W-1:0] DEFAULT_DURATION_RST = 16'd100;

  // Command codes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_SINGLE = 3'd1;
  localparam logic [OP_W-1:0] OP_REPEAT = 3'd2;
  localparam logic [OP_W-1:0] OP_CONT   = 3'd3;
  localparam logic [OP_W-1:0] OP_CANCEL = 3'd4;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEQ    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CONT   = 2'd3;

  // One registered input beat
  typedef struct packed {
    logic [COUNT_W-1:0] pulse_count;
    logic [LEN_W-1:0]   off_ticks;
    logic [LEN_W-1:0]   on_ticks;
    logic [OP_W-1:0]    op;
  } bpt_cmd_t;

  // Result of one step
  typedef struct packed {
    logic busy_res;
    logic buzzer_level;
  } bpt_res_t;

endpackage

@@ rtl/bpt_core.sv @@
module bpt_core
  import bpt_pkg::*;
#(
  parameter int unsigned TIME_BITS = DEFAULT_TIME_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  bpt_cmd_t         cmd,
  input  logic [LEN_W-1:0] default_duration,
  output bpt_res_t         res_nxt
);

  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [TIME_BITS-1:0] remaining_r, remaining_nxt;
  logic                 level_r, level_nxt;
  logic [COUNT_W-1:0]   pulses_r, pulses_nxt;
  logic [TIME_BITS-1:0] on_len_r, on_len_nxt;
  logic [TIME_BITS-1:0] off_len_r, off_len_nxt;

  logic [LEN_W-1:0]     single_len;
  logic [TIME_BITS-1:0] on_fit, off_fit, single_fit, rem_dec;
  logic [COUNT_W-1:0]   pulses_dec;
  logic                 phase_done;

  // Saturate a 16-bit length into the timer width
  function automatic logic [TIME_BITS-1:0] fit_time(input logic [LEN_W-1:0] v);
    logic [31:0] wide;
    wide = {{(32-LEN_W){1'b0}}, v};
    if ((wide >> TIME_BITS) != 32'd0) begin
      fit_time = '1;
    end else begin
      fit_time = wide[TIME_BITS-1:0];
    end
  endfunction

  assign single_len = (cmd.on_ticks == '0) ? default_duration : cmd.on_ticks;
  assign on_fit     = fit_time(cmd.on_ticks);
  assign off_fit    = fit_time(cmd.off_ticks);
  assign single_fit = fit_time(single_len);
  assign rem_dec    = remaining_r - TIME_BITS'(1);
  assign pulses_dec = pulses_r - COUNT_W'(1);
  // Phase ends when the counter is already zero or reaches zero now
  assign phase_done = (remaining_r == '0) || (rem_dec == '0);

  // Next state for one step
  always_comb begin
    mode_nxt      = mode_r;
    remaining_nxt = remaining_r;
    level_nxt     = level_r;
    pulses_nxt    = pulses_r;
    on_len_nxt    = on_len_r;
    off_len_nxt   = off_len_r;
    case (cmd.op)
      OP_TICK: begin
        if (mode_r != MODE_IDLE) begin
          if (!phase_done) begin
            remaining_nxt = rem_dec;
          end else if (mode_r == MODE_SINGLE ||
                       (mode_r == MODE_SEQ && !level_r && pulses_dec == '0)) begin
            mode_nxt      = MODE_IDLE;
            remaining_nxt = '0;
            level_nxt     = 1'b0;
            pulses_nxt    = '0;
            on_len_nxt    = '0;
            off_len_nxt   = '0;
          end else begin
            if (mode_r == MODE_SEQ && !level_r) begin
              pulses_nxt = pulses_dec;
            end
            remaining_nxt = level_r ? off_len_r : on_len_r;
            level_nxt     = !level_r;
          end
        end
      end
      OP_SINGLE: begin
        mode_nxt      = MODE_SINGLE;
        on_len_nxt    = single_fit;
        off_len_nxt   = '0;
        pulses_nxt    = '0;
        remaining_nxt = single_fit;
        level_nxt     = 1'b1;
      end
      OP_REPEAT: begin
        mode_nxt      = MODE_SEQ;
        on_len_nxt    = on_fit;
        off_len_nxt   = off_fit;
        pulses_nxt    = cmd.pulse_count;
        remaining_nxt = on_fit;
        level_nxt     = 1'b1;
      end
      OP_CONT: begin
        mode_nxt      = MODE_CONT;
        on_len_nxt    = on_fit;
        off_len_nxt   = off_fit;
        pulses_nxt    = '0;
        remaining_nxt = on_fit;
        level_nxt     = 1'b1;
      end
      OP_CANCEL: begin
        mode_nxt      = MODE_IDLE;
        remaining_nxt = '0;
        level_nxt     = 1'b0;
        pulses_nxt    = '0;
        on_len_nxt    = '0;
        off_len_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  assign res_nxt.buzzer_level = level_nxt;
  assign res_nxt.busy_res     = (mode_nxt != MODE_IDLE);

  // Pattern state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      remaining_r <= '0;
      level_r     <= 1'b0;
      pulses_r    <= '0;
      on_len_r    <= '0;
      off_len_r   <= '0;
    end else if (step_en) begin
      mode_r      <= mode_nxt;
      remaining_r <= remaining_nxt;
      level_r     <= level_nxt;
      pulses_r    <= pulses_nxt;
      on_len_r    <= on_len_nxt;
      off_len_r   <= off_len_nxt;
    end
  end

endmodule

@@ rtl/buzzer_pattern_timer.sv @@
// Channel | Dir | Ports                   | Beat contents
// in      | in  | in_tvalid/tready/tdata  | op, on_ticks, off_ticks, pulse_count
// out     | out | out_tvalid/tready/tdata | buzzer_level, busy_res
// cfg     | in  | cfg_valid/ready/data    | default_duration
//
// One input beat per cycle while the output is not stalled; its result
// passes through the input register, then the result register.
// The step logic between the two registers is the whole per-beat work.
// rst_n is synchronous: pattern idle, buzzer off, default_duration = 100.
// An output stall holds the result register and, once the input register
// is full, drops in_tready; no beat is lost or duplicated.
module buzzer_pattern_timer
  import bpt_pkg::*;
#(
  parameter int unsigned TIME_BITS = DEFAULT_TIME_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,   // op[2:0], on_ticks[18:3], off_ticks[34:19],
                                       // pulse_count[42:35], zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // buzzer_level[0], busy_res[1], zero pad
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data    // default_duration
);

  logic             in_vld_r;
  bpt_cmd_t         cmd_r;
  logic             out_vld_r;
  bpt_res_t         res_r;
  bpt_res_t         res_nxt;
  logic [LEN_W-1:0] default_duration_r;
  logic             advance;

  // Stage moves when the result register is free or being drained
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r <= in_tdata[$bits(bpt_cmd_t)-1:0];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_duration_r <= DEFAULT_DURATION_RST;
    end else if (cfg_valid && cfg_ready) begin
      default_duration_r <= cfg_data;
    end
  end

  bpt_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (in_vld_r && advance),
    .cmd              (cmd_r),
    .default_duration (default_duration_r),
    .res_nxt          (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, res_r};

endmodule

@@ rtl/bpt_checker.sv @@
module bpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // A stalled result beat stays valid
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its data
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // Buzzer never sounds while no pattern runs
  a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && !out_tdata[1]))
    else $error("buzzer on while idle");

  // A fresh result comes from an input beat taken through the input and result registers
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result beat without input beat");

endmodule

bind buzzer_pattern_timer bpt_checker u_bpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bpt_pkg::*;

  // Reserved command codes: the block must ignore them and report its state
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  localparam int unsigned RST_CYCLES   = 11;
  localparam int unsigned MAX_GAP      = 11;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned DRAIN_LIMIT  = 2000;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned PHASES       = 4;
  localparam int unsigned PHASE_BEATS  = 150;
  localparam int unsigned SHOW_MAX     = 10;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  // One directed row: a beat or a default_duration write (value in on_t)
  typedef struct packed {
    row_kind_e          kind;
    logic [OP_W-1:0]    op;
    logic [LEN_W-1:0]   on_t;
    logic [LEN_W-1:0]   off_t;
    logic [COUNT_W-1:0] cnt;
    logic               typed;
    logic               lvl;
    logic               busy;
  } dir_row_t;

  localparam int unsigned DIR_LEN = 26;
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    // tick while idle after reset
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b1, 1'b0, 1'b0},
    // single buzz with zero length takes the reset default
    '{ROW_BEAT, OP_SINGLE,  16'd0,     16'd0,     8'd0,   1'b1, 1'b1, 1'b1},
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, OP_CANCEL,  16'd0,     16'd0,     8'd0,   1'b1, 1'b0, 1'b0},
    '{ROW_BEAT, OP_SINGLE,  16'hFFFF,  16'hFFFF,  8'hFF,  1'b1, 1'b1, 1'b1},
    // reserved codes change nothing
    '{ROW_BEAT, OP_RSVD_LO, 16'hFFFF,  16'hFFFF,  8'hFF,  1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, OP_RSVD_HI, 16'h0000,  16'h0000,  8'h00,  1'b0, 1'b0, 1'b0},
    // two short pulses, run out to idle
    '{ROW_BEAT, OP_REPEAT,  16'd1,     16'd1,     8'd2,   1'b1, 1'b1, 1'b1},
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    // zero pulse count means 256, zero-length phases end on the next tick
    '{ROW_BEAT, OP_REPEAT,  16'd0,     16'd0,     8'd0,   1'b1, 1'b1, 1'b1},
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    // continuous, interrupted by cancel
    '{ROW_BEAT, OP_CONT,    16'd0,     16'hFFFF,  8'd0,   1'b1, 1'b1, 1'b1},
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, OP_CANCEL,  16'd0,     16'd0,     8'd0,   1'b1, 1'b0, 1'b0},
    // zero default and zero length
    '{ROW_CFG,  OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_BEAT, OP_SINGLE,  16'd0,     16'd0,     8'd0,   1'b1, 1'b1, 1'b1},
    '{ROW_BEAT, OP_TICK,    16'd0,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  OP_TICK,    16'hFFFF,  16'd0,     8'd0,   1'b0, 1'b0, 1'b0},
    // longest pattern, restarted by a new command
    '{ROW_BEAT, OP_REPEAT,  16'hFFFF,  16'hFFFF,  8'hFF,  1'b1, 1'b1, 1'b1},
    '{ROW_BEAT, OP_SINGLE,  16'd3,     16'd0,     8'd0,   1'b0, 1'b0, 1'b0}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [47:0]      in_tdata = '0;   // op, on_ticks, off_ticks, pulse_count, zero pad
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;       // buzzer_level, busy_res, zero pad
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;   // default_duration

  buzzer_pattern_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Predicted buzzer state
  logic [MODE_W-1:0]  pat_mode = MODE_IDLE;
  logic [LEN_W-1:0]   remain = '0;
  logic               lvl = 1'b0;
  logic [COUNT_W-1:0] pulses = '0;
  logic [LEN_W-1:0]   on_len = '0;
  logic [LEN_W-1:0]   off_len = '0;
  logic [LEN_W-1:0]   dflt_dur = DEFAULT_DURATION_RST;

  bpt_res_t    pending_res [$];
  int unsigned fault_cnt = 0;
  int unsigned beats_seen = 0;
  logic        quiet = 1'b0;

  function automatic void buzz_idle();
    pat_mode = MODE_IDLE;
    remain   = '0;
    lvl      = 1'b0;
    pulses   = '0;
    on_len   = '0;
    off_len  = '0;
  endfunction

  function automatic void load_pattern(input logic [LEN_W-1:0] on_t,
                                       input logic [LEN_W-1:0] off_t,
                                       input logic [COUNT_W-1:0] cnt,
                                       input logic [MODE_W-1:0] m);
    pat_mode = m;
    on_len   = on_t;
    off_len  = off_t;
    pulses   = cnt;
    remain   = on_t;
    lvl      = 1'b1;
  endfunction

  // End of the current on or off phase
  function automatic void phase_done();
    if (pat_mode == MODE_SINGLE) begin
      buzz_idle();
    end else if (pat_mode == MODE_SEQ && !lvl && pulses == 8'd1) begin
      buzz_idle();
    end else begin
      if (pat_mode == MODE_SEQ && !lvl) pulses = pulses - COUNT_W'(1);
      remain = lvl ? off_len : on_len;
      lvl    = ~lvl;
    end
  endfunction

  function automatic bpt_res_t step_buzzer(input bpt_cmd_t c);
    bpt_res_t r;
    case (c.op)
      OP_TICK: begin
        if (pat_mode != MODE_IDLE) begin
          if (remain == '0) begin
            phase_done();
          end else begin
            remain = remain - LEN_W'(1);
            if (remain == '0) phase_done();
          end
        end
      end
      OP_SINGLE: load_pattern((c.on_ticks == '0) ? dflt_dur : c.on_ticks, '0, '0, MODE_SINGLE);
      OP_REPEAT: load_pattern(c.on_ticks, c.off_ticks, c.pulse_count, MODE_SEQ);
      OP_CONT:   load_pattern(c.on_ticks, c.off_ticks, '0, MODE_CONT);
      OP_CANCEL: buzz_idle();
      default: ;
    endcase
    r.buzzer_level = lvl;
    r.busy_res     = (pat_mode != MODE_IDLE);
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Mostly ticks so that phases actually run out
  function automatic logic [OP_W-1:0] rand_op();
    int unsigned w = $urandom_range(0, 99);
    if (w < 60) return OP_TICK;
    if (w < 70) return OP_SINGLE;
    if (w < 80) return OP_REPEAT;
    if (w < 88) return OP_CONT;
    if (w < 94) return OP_CANCEL;
    return OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
  endfunction

  // Short lengths reach phase ends, full range exercises every bit
  function automatic logic [LEN_W-1:0] rand_len();
    if ($urandom_range(0, 9) < 8) return LEN_W'($urandom_range(0, 4));
    return LEN_W'($urandom);
  endfunction

  function automatic logic [COUNT_W-1:0] rand_cnt();
    if ($urandom_range(0, 9) < 7) return COUNT_W'($urandom_range(0, 3));
    return COUNT_W'($urandom);
  endfunction

  // Offer one beat, entered right after a rising edge
  task automatic send_item(input bpt_cmd_t c, input int unsigned gap,
                           input logic use_typed, input bpt_res_t typed_res);
    bpt_res_t pred;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(48 - $bits(bpt_cmd_t)){1'b0}}, c};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = step_buzzer(c);
    pending_res.push_back(use_typed ? typed_res : pred);
  endtask

  // Register write with no input beat in flight
  task automatic write_default(input logic [LEN_W-1:0] v);
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dflt_dur = v;
  endtask

  task automatic note_mismatch(input string what, input logic e, input logic a);
    fault_cnt++;
    if (fault_cnt <= SHOW_MAX)
      $display("mismatch beat %0d %s: expected %0b, got %0b", beats_seen, what, e, a);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, one long hold-off to back up the input
  initial begin
    int unsigned stall;
    bpt_res_t    got;
    bpt_res_t    want;
    logic        held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (beats_seen == HOLD_AT && !held) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = out_tdata[$bits(bpt_res_t)-1:0];
      if (pending_res.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= SHOW_MAX)
          $display("unexpected beat %0d: got %b", beats_seen, out_tdata);
      end else begin
        want = pending_res.pop_front();
        if (got.buzzer_level !== want.buzzer_level)
          note_mismatch("buzzer_level", want.buzzer_level, got.buzzer_level);
        if (got.busy_res !== want.busy_res)
          note_mismatch("busy_res", want.busy_res, got.busy_res);
      end
      beats_seen++;
    end
  end

  // Stimulus
  initial begin
    bpt_cmd_t         cmd;
    dir_row_t         row;
    logic [LEN_W-1:0] cfg_val;
    int unsigned      wait_cnt;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows
    for (int i = 0; i < DIR_LEN; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) begin
        write_default(row.on_t);
      end else begin
        cmd.op          = row.op;
        cmd.on_ticks    = row.on_t;
        cmd.off_ticks   = row.off_t;
        cmd.pulse_count = row.cnt;
        send_item(cmd, draw_gap(), row.typed, '{busy_res: row.busy, buzzer_level: row.lvl});
      end
    end

    // Random phases, each under its own default_duration
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       cfg_val = LEN_W'($urandom_range(1, 6));
        1:       cfg_val = 16'hFFFF;
        2:       cfg_val = 16'h0000;
        default: cfg_val = LEN_W'($urandom);
      endcase
      write_default(cfg_val);
      quiet = (ph == 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        cmd.op          = rand_op();
        cmd.on_ticks    = rand_len();
        cmd.off_ticks   = rand_len();
        cmd.pulse_count = rand_cnt();
        send_item(cmd, draw_gap(), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    // Drain
    in_tvalid <= 1'b0;
    wait_cnt = 0;
    while (pending_res.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    fault_cnt += pending_res.size();
    if (fault_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
